@@ hw/rtl/http_byte_range_decider_macros.svh @@
// Assertion macros shared by the byte-range decider RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef HTTP_BYTE_RANGE_DECIDER_MACROS_SVH
`define HTTP_BYTE_RANGE_DECIDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HBRD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbrd assertion failed");

// Next-cycle implication, checked outside reset.
`define HBRD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbrd assertion failed");

`endif

@@ hw/rtl/hbrd_pkg.sv @@
// Shared types, codes and character helpers for the byte-range decider.
// No dependencies; imported by every RTL module of the block.
package hbrd_pkg;

	// Port field widths
	localparam int FIELD_W     = 63;
	localparam int CHAR_W      = 8;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 128;
	localparam int CFG_IDX_W   = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAP_LENGTH     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_THRESHOLD = 1'b1;

	// Response decision codes
	typedef enum logic [1:0] {
		DEC_FULL      = 2'd0,
		DEC_PARTIAL   = 2'd1,
		DEC_TOO_LARGE = 2'd2,
		DEC_UNSAT     = 2'd3
	} dec_t;

	// Parser phases, one-hot
	typedef enum logic [12:0] {
		PH_U_LEAD  = 13'h0001,
		PH_U_WORD  = 13'h0002,
		PH_U_TAIL  = 13'h0004,
		PH_L_LEAD  = 13'h0008,
		PH_L_SIGN  = 13'h0010,
		PH_L_DIG   = 13'h0020,
		PH_L_TRAIL = 13'h0040,
		PH_R_LEAD  = 13'h0080,
		PH_R_SIGN  = 13'h0100,
		PH_R_DIG   = 13'h0200,
		PH_R_TRAIL = 13'h0400,
		PH_CLOSED  = 13'h0800,
		PH_DEAD    = 13'h1000
	} phase_t;

	// Token flags gathered while parsing the spec
	typedef struct packed {
		logic lhs_nonempty;
		logic suffix;
		logic rhs_nonempty;
		logic rhs_present;
	} flags_t;

	// Control part of a finished header, handed from parser to decider
	typedef struct packed {
		logic ok;
		logic suffix;
		logic rhs_present;
	} snap_ctl_t;

	// Characters
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

	// Unit word "bytes"
	localparam logic [2:0] UNIT_LEN = 3'd5;

	function automatic logic [CHAR_W-1:0] unit_char(input logic [2:0] pos);
		logic [CHAR_W-1:0] ch;
		unique case (pos)
			3'd0: ch = 8'h62;
			3'd1: ch = 8'h79;
			3'd2: ch = 8'h74;
			3'd3: ch = 8'h65;
			3'd4: ch = 8'h73;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_st(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	// LF, VT, FF, CR
	function automatic logic is_ws4(input logic [CHAR_W-1:0] c);
		return (c >= CH_LF) && (c <= CH_CR);
	endfunction

	function automatic logic is_dig(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_DIFF : c;
	endfunction

endpackage

@@ hw/rtl/hbrd_parser.sv @@
// Input register and Range header parser: one byte per cycle, but a final byte waits until the snapshot is taken.
// Depends on hbrd_pkg and the assertion macros header.
`include "http_byte_range_decider_macros.svh"

module hbrd_parser
	import hbrd_pkg::*;
#(
	parameter int SIZE_BITS = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CHAR_W-1:0]    in_char,
	input  logic                 in_present,
	input  logic                 in_final,
	input  logic [FIELD_W-1:0]   in_size,
	output logic                 snap_valid,
	input  logic                 snap_ready,
	output snap_ctl_t            snap_ctl,
	output logic [SIZE_BITS-1:0] snap_left,
	output logic [SIZE_BITS-1:0] snap_right,
	output logic [SIZE_BITS-1:0] snap_size
);

	localparam int ACC_W = SIZE_BITS + 4;

	// Input stage
	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic                 present_s1;
	logic                 final_s1;
	logic [SIZE_BITS-1:0] size_s1;

	// Parser state
	phase_t               phase_q;
	logic [2:0]           upos_q;
	logic [SIZE_BITS-1:0] left_q;
	logic [SIZE_BITS-1:0] right_q;
	flags_t               flags_q;
	logic                 invalid_q;

	// Next-state values
	phase_t               phase_n;
	logic [2:0]           upos_n;
	logic [SIZE_BITS-1:0] left_n;
	logic [SIZE_BITS-1:0] right_n;
	flags_t               flags_n;
	logic                 invalid_n;
	logic                 dead;

	logic [ACC_W-1:0]     digit_ext;
	logic [ACC_W-1:0]     acc_left;
	logic [ACC_W-1:0]     acc_right;
	logic                 ovf_left;
	logic                 ovf_right;
	logic [SIZE_BITS-1:0] first_digit;
	logic                 rlead_close;

	logic                 snap_take;
	logic                 consume;
	snap_ctl_t            ctl_n;

	// Handshake: a non-final byte never waits on the result side
	assign snap_take = !snap_valid || snap_ready;
	assign consume   = valid_s1 && (!final_s1 || snap_take);
	assign in_ready  = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !consume);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1    <= in_char;
			present_s1 <= in_present;
			final_s1   <= in_final;
			size_s1    <= in_size[SIZE_BITS-1:0];
		end
	end

	// Decimal accumulate: v*10 + d, overflow when top bits are set
	assign digit_ext   = ACC_W'(char_s1[3:0]);
	assign first_digit = SIZE_BITS'(char_s1[3:0]);
	assign acc_left    = (ACC_W'(left_q) << 3) + (ACC_W'(left_q) << 1) + digit_ext;
	assign acc_right   = (ACC_W'(right_q) << 3) + (ACC_W'(right_q) << 1) + digit_ext;
	assign ovf_left    = |acc_left[ACC_W-1:SIZE_BITS];
	assign ovf_right   = |acc_right[ACC_W-1:SIZE_BITS];

	// Empty right side may close only for "first-" without stray whitespace
	assign rlead_close = !(flags_q.rhs_nonempty || flags_q.suffix);

	// Per-byte parser step
	always_comb begin
		phase_n   = phase_q;
		upos_n    = upos_q;
		left_n    = left_q;
		right_n   = right_q;
		flags_n   = flags_q;
		invalid_n = invalid_q;
		dead      = 1'b0;
		if (present_s1) begin
			unique case (phase_q)
				PH_U_LEAD: begin
					if (!is_st(char_s1)) begin
						if (to_lower(char_s1) == unit_char(3'd0)) begin
							upos_n  = 3'd1;
							phase_n = PH_U_WORD;
						end else begin
							dead = 1'b1;
						end
					end
				end
				PH_U_WORD: begin
					if ((upos_q < UNIT_LEN) && (to_lower(char_s1) == unit_char(upos_q))) begin
						upos_n = 3'(upos_q + 3'd1);
						if (3'(upos_q + 3'd1) == UNIT_LEN) begin
							phase_n = PH_U_TAIL;
						end
					end else begin
						dead = 1'b1;
					end
				end
				PH_U_TAIL: begin
					if (!is_st(char_s1)) begin
						if (char_s1 == CH_EQUALS) phase_n = PH_L_LEAD;
						else dead = 1'b1;
					end
				end
				PH_L_LEAD: begin
					if (!is_st(char_s1)) begin
						priority if (is_ws4(char_s1)) begin
							flags_n.lhs_nonempty = 1'b1;
						end else if (char_s1 == CH_PLUS) begin
							phase_n = PH_L_SIGN;
						end else if (is_dig(char_s1)) begin
							left_n  = first_digit;
							phase_n = PH_L_DIG;
						end else if ((char_s1 == CH_DASH) && !flags_q.lhs_nonempty) begin
							flags_n.suffix = 1'b1;
							phase_n        = PH_R_LEAD;
						end else begin
							dead = 1'b1;
						end
					end
				end
				PH_L_SIGN: begin
					if (is_dig(char_s1)) begin
						left_n  = first_digit;
						phase_n = PH_L_DIG;
					end else begin
						dead = 1'b1;
					end
				end
				PH_L_DIG: begin
					priority if (is_dig(char_s1)) begin
						if (ovf_left) dead = 1'b1;
						else left_n = acc_left[SIZE_BITS-1:0];
					end else if (is_st(char_s1)) begin
						phase_n = PH_L_TRAIL;
					end else if (char_s1 == CH_DASH) begin
						phase_n = PH_R_LEAD;
					end else begin
						dead = 1'b1;
					end
				end
				PH_L_TRAIL: begin
					if (!is_st(char_s1)) begin
						if (char_s1 == CH_DASH) phase_n = PH_R_LEAD;
						else dead = 1'b1;
					end
				end
				PH_R_LEAD: begin
					if (!is_st(char_s1)) begin
						priority if (is_ws4(char_s1)) begin
							flags_n.rhs_nonempty = 1'b1;
						end else if (char_s1 == CH_PLUS) begin
							phase_n = PH_R_SIGN;
						end else if (is_dig(char_s1)) begin
							right_n             = first_digit;
							flags_n.rhs_present = 1'b1;
							phase_n             = PH_R_DIG;
						end else if (char_s1 == CH_COMMA) begin
							if (rlead_close) phase_n = PH_CLOSED;
							else dead = 1'b1;
						end else begin
							dead = 1'b1;
						end
					end
				end
				PH_R_SIGN: begin
					if (is_dig(char_s1)) begin
						right_n             = first_digit;
						flags_n.rhs_present = 1'b1;
						phase_n             = PH_R_DIG;
					end else begin
						dead = 1'b1;
					end
				end
				PH_R_DIG: begin
					priority if (is_dig(char_s1)) begin
						if (ovf_right) dead = 1'b1;
						else right_n = acc_right[SIZE_BITS-1:0];
					end else if (is_st(char_s1)) begin
						phase_n = PH_R_TRAIL;
					end else if (char_s1 == CH_COMMA) begin
						phase_n = PH_CLOSED;
					end else begin
						dead = 1'b1;
					end
				end
				PH_R_TRAIL: begin
					if (!is_st(char_s1)) begin
						if (char_s1 == CH_COMMA) phase_n = PH_CLOSED;
						else dead = 1'b1;
					end
				end
				PH_CLOSED: begin
				end
				PH_DEAD: begin
					dead = 1'b1;
				end
				default: begin
					dead = 1'b1;
				end
			endcase
			if (dead) begin
				phase_n   = PH_DEAD;
				invalid_n = 1'b1;
			end
		end
	end

	// Spec validity at end of header
	always_comb begin
		ctl_n.suffix      = flags_n.suffix;
		ctl_n.rhs_present = flags_n.rhs_present;
		ctl_n.ok          = !invalid_n && ((phase_n == PH_CLOSED) ||
			(phase_n == PH_R_DIG) || (phase_n == PH_R_TRAIL) ||
			((phase_n == PH_R_LEAD) && !(flags_n.rhs_nonempty || flags_n.suffix)));
	end

	// Parser state: cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_U_LEAD;
			upos_q    <= 3'd0;
			left_q    <= '0;
			right_q   <= '0;
			flags_q   <= '0;
			invalid_q <= 1'b0;
		end else if (consume) begin
			if (final_s1) begin
				phase_q   <= PH_U_LEAD;
				upos_q    <= 3'd0;
				left_q    <= '0;
				right_q   <= '0;
				flags_q   <= '0;
				invalid_q <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				upos_q    <= upos_n;
				left_q    <= left_n;
				right_q   <= right_n;
				flags_q   <= flags_n;
				invalid_q <= invalid_n;
			end
		end
	end

	// Snapshot stage toward the decider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid <= 1'b0;
		end else begin
			snap_valid <= (consume && final_s1) || (snap_valid && !snap_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (consume && final_s1) begin
			snap_ctl   <= ctl_n;
			snap_left  <= left_n;
			snap_right <= right_n;
			snap_size  <= size_s1;
		end
	end

	`HBRD_ASSERT_NXT(a_clear_after_final, consume && final_s1, phase_q == PH_U_LEAD && left_q == '0)
	`HBRD_ASSERT_NXT(a_final_makes_snap, consume && final_s1, snap_valid)
	`HBRD_ASSERT_IMP(a_invalid_is_dead, invalid_q, phase_q == PH_DEAD)

endmodule

@@ hw/rtl/hbrd_decider.sv @@
// Range decision: bounds check and arithmetic stage, then length cap stage.
// Depends on hbrd_pkg and the assertion macros header.
`include "http_byte_range_decider_macros.svh"

module hbrd_decider
	import hbrd_pkg::*;
#(
	parameter int SIZE_BITS = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 snap_valid,
	output logic                 snap_ready,
	input  snap_ctl_t            snap_ctl,
	input  logic [SIZE_BITS-1:0] snap_left,
	input  logic [SIZE_BITS-1:0] snap_right,
	input  logic [SIZE_BITS-1:0] snap_size,
	input  logic [SIZE_BITS-1:0] cap_length,
	input  logic [SIZE_BITS-1:0] full_threshold,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dec_t                 out_decision,
	output logic [SIZE_BITS-1:0] out_start,
	output logic [SIZE_BITS-1:0] out_length
);

	// Decision stage
	logic                 valid_s3;
	dec_t                 dec_s3;
	logic [SIZE_BITS-1:0] start_s3;
	logic [SIZE_BITS-1:0] len_s3;

	// Output register
	logic                 out_valid_q;
	dec_t                 dec_q;
	logic [SIZE_BITS-1:0] start_q;
	logic [SIZE_BITS-1:0] len_q;

	logic                 out_take;
	logic                 s3_take;

	dec_t                 dec_c;
	logic [SIZE_BITS-1:0] start_c;
	logic [SIZE_BITS-1:0] len_c;
	logic [SIZE_BITS-1:0] size_m1;
	logic [SIZE_BITS-1:0] suffix_n;
	logic [SIZE_BITS-1:0] last_pos;
	logic                 bad;

	assign out_take   = !out_valid_q || out_ready;
	assign s3_take    = !valid_s3 || out_take;
	assign snap_ready = s3_take;

	assign size_m1  = snap_size - SIZE_BITS'(1);
	assign suffix_n = (snap_right > snap_size) ? snap_size : snap_right;
	assign last_pos = (snap_ctl.rhs_present && (snap_right < size_m1)) ? snap_right : size_m1;
	assign bad      = !snap_ctl.ok ||
		(!snap_ctl.suffix && snap_ctl.rhs_present && (snap_right < snap_left));

	// Classify and compute offset and raw length
	always_comb begin
		dec_c   = DEC_FULL;
		start_c = '0;
		len_c   = '0;
		priority if (bad) begin
			if (snap_size > full_threshold) begin
				dec_c = DEC_TOO_LARGE;
			end else begin
				dec_c = DEC_FULL;
				len_c = snap_size;
			end
		end else if (snap_ctl.suffix) begin
			if (snap_right == '0) begin
				dec_c = DEC_UNSAT;
			end else begin
				dec_c   = DEC_PARTIAL;
				start_c = snap_size - suffix_n;
				len_c   = suffix_n;
			end
		end else if (snap_left >= snap_size) begin
			dec_c = DEC_UNSAT;
		end else begin
			dec_c   = DEC_PARTIAL;
			start_c = snap_left;
			len_c   = last_pos - snap_left + SIZE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_take) begin
			valid_s3 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_take && snap_valid) begin
			dec_s3   <= dec_c;
			start_s3 <= start_c;
			len_s3   <= len_c;
		end
	end

	// Cap the length of a partial answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s3) begin
			dec_q   <= dec_s3;
			start_q <= start_s3;
			len_q   <= ((dec_s3 == DEC_PARTIAL) && (len_s3 > cap_length)) ? cap_length : len_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_decision = dec_q;
	assign out_start    = start_q;
	assign out_length   = len_q;

	`HBRD_ASSERT_NXT(a_s3_reaches_out, valid_s3 && out_take, out_valid_q)
	`HBRD_ASSERT_IMP(a_error_is_empty, out_valid_q && (dec_q == DEC_TOO_LARGE || dec_q == DEC_UNSAT), start_q == '0 && len_q == '0)
	`HBRD_ASSERT_IMP(a_full_from_zero, out_valid_q && dec_q == DEC_FULL, start_q == '0)

endmodule

@@ hw/rtl/http_byte_range_decider.sv @@
// Top level of the HTTP byte-range decider: stream ports, config registers.
// Depends on hbrd_pkg, hbrd_parser and hbrd_decider.
//
// Takes an HTTP Range header one byte per transfer on the slave stream
// (tlast marks the last byte, tuser says whether the byte is real) and,
// for each header, gives one decision on the master stream: full 200,
// partial 206, too large 413 or unsatisfiable 416, with the start offset
// and the byte count to send. One byte is taken every clock cycle, but a
// last byte may wait; the parser advances its state once per byte, so
// that loop sets the rate. A decision for a last byte passes from the input
// register through the parser snapshot, the bounds and length arithmetic
// and the length cap to the output register. Bytes that are not last keep
// flowing while a decision waits on the master side; only a last byte
// waits for room. cap_length and full_threshold reset to all ones. The user
// writes them only while no header is in flight; the block does not enforce it.
module http_byte_range_decider
	import hbrd_pkg::*;
#(
	parameter int SIZE_BITS = 63
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FIELD_W-1:0]     cfg_data,
	// Header byte stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // header_char[7:0], resource_size[70:8]
	input  logic [0:0]             s_axis_tuser,  // char_present[0]
	input  logic                   s_axis_tlast,  // final_char
	// Decision stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // start_offset[62:0], send_length[125:63]
	output logic [1:0]             m_axis_tuser   // decision[1:0]
);

	logic [SIZE_BITS-1:0] cap_q;
	logic [SIZE_BITS-1:0] thr_q;

	logic                 snap_valid;
	logic                 snap_ready;
	snap_ctl_t            snap_ctl;
	logic [SIZE_BITS-1:0] snap_left;
	logic [SIZE_BITS-1:0] snap_right;
	logic [SIZE_BITS-1:0] snap_size;

	dec_t                 decision;
	logic [SIZE_BITS-1:0] start_off;
	logic [SIZE_BITS-1:0] send_len;

	// Config registers, low SIZE_BITS bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
			thr_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAP_LENGTH:     cap_q <= cfg_data[SIZE_BITS-1:0];
				CFG_FULL_THRESHOLD: thr_q <= cfg_data[SIZE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	hbrd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_char   (s_axis_tdata[CHAR_W-1:0]),
		.in_present(s_axis_tuser[0]),
		.in_final  (s_axis_tlast),
		.in_size   (s_axis_tdata[CHAR_W+FIELD_W-1:CHAR_W]),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap_ctl  (snap_ctl),
		.snap_left (snap_left),
		.snap_right(snap_right),
		.snap_size (snap_size)
	);

	hbrd_decider #(
		.SIZE_BITS(SIZE_BITS)
	) u_decider (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap_ready    (snap_ready),
		.snap_ctl      (snap_ctl),
		.snap_left     (snap_left),
		.snap_right    (snap_right),
		.snap_size     (snap_size),
		.cap_length    (cap_q),
		.full_threshold(thr_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_decision  (decision),
		.out_start     (start_off),
		.out_length    (send_len)
	);

	// Pack the result, zero-extended to the port field widths
	assign m_axis_tuser = decision;
	assign m_axis_tdata = {
		(OUT_TDATA_W - 2 * FIELD_W)'(0),
		FIELD_W'(send_len),
		FIELD_W'(start_off)
	};

endmodule
